// ===== src/sorted_key_find_or_insert_unit_macros.svh =====
// ----------------------------------------------------------------------------
// sorted key find-or-insert unit: assertion macros
// shared property forms, sampled on aclk and held off during reset
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_FIND_OR_INSERT_UNIT_MACROS_SVH
`define SORTED_KEY_FIND_OR_INSERT_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SKFI_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SKFI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/skfi_pkg.sv =====
// ----------------------------------------------------------------------------
// skfi_pkg
// shared types and sequencer codes of the sorted key find-or-insert unit
// ----------------------------------------------------------------------------
package skfi_pkg;

    // outcome of one item, exactly one bit set
    typedef struct packed {
        logic found;
        logic inserted;
        logic full;
    } flags_t;

    // sequencer state codes
    localparam int unsigned STATE_W = 3;
    typedef logic [STATE_W-1:0] state_t;

    localparam state_t ST_IDLE  = 3'd0;
    localparam state_t ST_PROBE = 3'd1;
    localparam state_t ST_CMP   = 3'd2;
    localparam state_t ST_SHIFT = 3'd3;
    localparam state_t ST_PUT   = 3'd4;
    localparam state_t ST_DONE  = 3'd5;

endpackage

// ===== src/sorted_key_find_or_insert_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_key_find_or_insert_unit
// sorted table of distinct keys with binary search and ordered insertion
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  s_      | in  | s_valid / s_ready  | s_key
//  m_      | out | m_valid / m_ready  | m_found m_inserted m_full_res
//          |     |                    | m_position m_count_after
//
//  one item at a time; each probe of the binary search is a ram read,
//  then a compare, set by the single registered read port of the key ram;
//  a search makes at most ceil(log2(count+1)) probes; a hit or a miss on
//  a full table then goes to the result, an insert first moves every
//  entry at and above the insertion point up one slot; ready returns
//  in the same cycle the result appears
//  aresetn (synchronous, active low) empties the table; ram contents are
//  not cleared since only slots below the count are ever read
//  the result sits in an output register, so a new item is taken while
//  the previous result waits; the sequencer stalls in its last step only
//  when a second result is ready and the first one is still not taken
// ----------------------------------------------------------------------------
module sorted_key_find_or_insert_unit
    import skfi_pkg::*;
#(
    parameter int unsigned CAPACITY = 64,
    parameter int unsigned KEY_BITS = 31
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [KEY_BITS-1:0]               s_key,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_found,
    output logic                              m_inserted,
    output logic                              m_full_res,
    output logic [$clog2(CAPACITY)-1:0]       m_position,
    output logic [$clog2(CAPACITY+1)-1:0]     m_count_after
);

    localparam int unsigned POS_W = $clog2(CAPACITY);
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(CAPACITY - 1);

    // sequencer and table state
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    // search window [lo, hi) and current probe
    logic [CNT_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]    hi_reg, hi_next;
    logic [POS_W-1:0]    mid_reg, mid_next;
    logic [KEY_BITS-1:0] key_reg, key_next;

    // slot whose contents are being moved up during the shift
    logic [POS_W-1:0]    src_reg, src_next;

    // staged result and output register
    flags_t              res_flags_reg, res_flags_next;
    logic [POS_W-1:0]    res_pos_reg, res_pos_next;
    logic                m_valid_reg, m_valid_next;
    flags_t              out_flags_reg, out_flags_next;
    logic [POS_W-1:0]    out_pos_reg, out_pos_next;
    logic [CNT_W-1:0]    out_cnt_reg, out_cnt_next;

    // ram ports
    logic                ram_we;
    logic [POS_W-1:0]    ram_waddr;
    logic [KEY_BITS-1:0] ram_wdata;
    logic [POS_W-1:0]    ram_raddr;
    logic [KEY_BITS-1:0] ram_rdata;

    // midpoint of the window, always below the capacity while lo < hi
    logic [CNT_W:0]      mid_sum;
    logic [POS_W-1:0]    mid;
    logic                out_free;

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[POS_W:1];
    assign out_free = !m_valid_reg || m_ready;

    skfi_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        src_next       = src_reg;
        res_flags_next = res_flags_reg;
        res_pos_next   = res_pos_reg;
        out_flags_next = out_flags_reg;
        out_pos_next   = out_pos_reg;
        out_cnt_next   = out_cnt_reg;
        m_valid_next   = m_valid_reg;

        ram_we    = 1'b0;
        ram_waddr = src_reg + POS_W'(1);
        ram_wdata = ram_rdata;
        ram_raddr = mid;

        // result taken downstream
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    key_next   = s_key;
                    lo_next    = '0;
                    hi_next    = count_reg;
                    state_next = ST_PROBE;
                end
            end

            ST_PROBE: begin
                if (lo_reg < hi_reg) begin
                    // read the middle entry
                    ram_raddr  = mid;
                    mid_next   = mid;
                    state_next = ST_CMP;
                end else if (count_reg == CAP_CNT) begin
                    // absent and no room: report saturated insertion point
                    res_flags_next = '{found: 1'b0, inserted: 1'b0, full: 1'b1};
                    res_pos_next   = (lo_reg >= CAP_CNT) ? LAST_POS : lo_reg[POS_W-1:0];
                    state_next     = ST_DONE;
                end else if (lo_reg < count_reg) begin
                    // entries at and above lo move up, top one first
                    ram_raddr  = POS_W'(count_reg - CNT_W'(1));
                    src_next   = POS_W'(count_reg - CNT_W'(1));
                    state_next = ST_SHIFT;
                end else begin
                    state_next = ST_PUT;
                end
            end

            ST_CMP: begin
                if (ram_rdata == key_reg) begin
                    res_flags_next = '{found: 1'b1, inserted: 1'b0, full: 1'b0};
                    res_pos_next   = mid_reg;
                    state_next     = ST_DONE;
                end else if (ram_rdata < key_reg) begin
                    lo_next    = CNT_W'(mid_reg) + CNT_W'(1);
                    state_next = ST_PROBE;
                end else begin
                    hi_next    = CNT_W'(mid_reg);
                    state_next = ST_PROBE;
                end
            end

            ST_SHIFT: begin
                // read data holds slot src; it goes to src + 1
                ram_we    = 1'b1;
                ram_waddr = src_reg + POS_W'(1);
                ram_wdata = ram_rdata;
                if (CNT_W'(src_reg) == lo_reg) begin
                    state_next = ST_PUT;
                end else begin
                    ram_raddr = src_reg - POS_W'(1);
                    src_next  = src_reg - POS_W'(1);
                end
            end

            ST_PUT: begin
                ram_we         = 1'b1;
                ram_waddr      = lo_reg[POS_W-1:0];
                ram_wdata      = key_reg;
                count_next     = count_reg + CNT_W'(1);
                res_flags_next = '{found: 1'b0, inserted: 1'b1, full: 1'b0};
                res_pos_next   = lo_reg[POS_W-1:0];
                state_next     = ST_DONE;
            end

            ST_DONE: begin
                // hand the result to the output register once it is free
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    out_flags_next = res_flags_reg;
                    out_pos_next   = res_pos_reg;
                    out_cnt_next   = count_reg;
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        key_reg       <= key_next;
        src_reg       <= src_next;
        res_flags_reg <= res_flags_next;
        res_pos_reg   <= res_pos_next;
        out_flags_reg <= out_flags_next;
        out_pos_reg   <= out_pos_next;
        out_cnt_reg   <= out_cnt_next;
    end

    // ports
    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_found       = out_flags_reg.found;
    assign m_inserted    = out_flags_reg.inserted;
    assign m_full_res    = out_flags_reg.full;
    assign m_position    = out_pos_reg;
    assign m_count_after = out_cnt_reg;

endmodule

// ===== src/skfi_ram.sv =====
// ----------------------------------------------------------------------------
// skfi_ram
// generic single-clock ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module skfi_ram #(
    parameter int unsigned WIDTH = 31,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/skfi_chk.sv =====
// ----------------------------------------------------------------------------
// skfi_chk
// port-level checks of the sorted key find-or-insert unit
// ----------------------------------------------------------------------------
`include "sorted_key_find_or_insert_unit_macros.svh"

module skfi_chk
    import skfi_pkg::*;
#(
    parameter int unsigned CAPACITY = 64,
    parameter int unsigned KEY_BITS = 31
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_found,
    input logic                          m_inserted,
    input logic                          m_full_res,
    input logic [$clog2(CAPACITY)-1:0]   m_position,
    input logic [$clog2(CAPACITY+1)-1:0] m_count_after
);

    localparam int unsigned POS_W = $clog2(CAPACITY);
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    flags_t                   flags;
    logic                     s_fire;
    logic                     m_stall;
    logic                     keeps_key;
    logic                     pos_ok;
    logic                     full_ok;
    logic [3+POS_W+CNT_W-1:0] res_bus;

    assign flags     = '{found: m_found, inserted: m_inserted, full: m_full_res};
    assign s_fire    = s_valid && s_ready;
    assign m_stall   = m_valid && !m_ready;
    assign keeps_key = m_valid && (m_found || m_inserted);
    assign pos_ok    = (CNT_W'(m_position) < m_count_after);
    assign full_ok   = (m_count_after == CAP_CNT);
    assign res_bus   = {m_found, m_inserted, m_full_res, m_position, m_count_after};

    // every result carries exactly one outcome
    `SKFI_ASSERT_SAME(a_one_outcome, m_valid, $onehot(flags), "result outcome not one-hot")

    // a found or inserted key sits inside the valid part of the table
    `SKFI_ASSERT_SAME(a_pos_valid, keeps_key, pos_ok, "position beyond entry count")

    // a full report only comes from a table at capacity
    `SKFI_ASSERT_SAME(a_full_count, m_valid && m_full_res, full_ok, "full reported below capacity")

    // the block is busy in the cycle after it takes an item
    `SKFI_ASSERT_NEXT(a_busy_after_accept, s_fire, !s_ready, "ready right after accept")

    // a stalled result holds
    `SKFI_ASSERT_NEXT(a_hold, m_stall, m_valid && $stable(res_bus), "stalled result changed")

endmodule

bind sorted_key_find_or_insert_unit skfi_chk #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
) u_skfi_chk (.*);

// ===== test/sorted_key_find_or_insert_unit_test.sv =====
// ----------------------------------------------------------------------------
// sorted_key_find_or_insert_unit_test
// self-checking bench: keys are pushed through the request channel with
// random gaps, a shadow copy of the sorted table predicts every result, and
// each result is compared field by field in arrival order
// ----------------------------------------------------------------------------
module sorted_key_find_or_insert_unit_test;
    import skfi_pkg::*;

    localparam int unsigned KEY_W     = 31;
    localparam int unsigned SLOTS     = 64;
    localparam int unsigned POS_W     = $clog2(SLOTS);
    localparam int unsigned CNT_W     = $clog2(SLOTS + 1);
    localparam int unsigned MAX_CYCLE = 800000;
    localparam int unsigned PHASE_LEN = 450;
    localparam int unsigned TAIL_WAIT = 200;

    typedef logic [KEY_W-1:0] key_t;

    // one predicted result
    typedef struct {
        flags_t             flags;
        logic [POS_W-1:0]   position;
        logic [CNT_W-1:0]   count_after;
    } lookup_result_t;

    // shadow of the sorted table plus the queue of results still owed
    class sorted_table_tracker;
        key_t           held_keys[SLOTS];
        int unsigned    held_count;
        lookup_result_t owed_results[$];
        int unsigned    mismatches;

        function new();
            held_count = 0;
            mismatches = 0;
        endfunction

        task report(input string msg);
            mismatches++;
            if (mismatches <= 30)
                $display("mismatch: %s", msg);
        endtask

        function int unsigned pending();
            return owed_results.size();
        endfunction

        function bit is_full();
            return held_count >= SLOTS;
        endfunction

        // binary search, then insert at the lower bound when the key is absent and there is room
        function void note_request(input key_t k);
            int unsigned    lo;
            int unsigned    hi;
            int unsigned    mid;
            int unsigned    i;
            bit             hit;
            lookup_result_t r;
            lo  = 0;
            hi  = held_count;
            hit = 1'b0;
            while (lo < hi && !hit) begin
                mid = (lo + hi) / 2;
                if (held_keys[mid] == k) begin
                    hit = 1'b1;
                    lo  = mid;
                end else if (held_keys[mid] < k) begin
                    lo = mid + 1;
                end else begin
                    hi = mid;
                end
            end
            r.flags = '0;
            if (hit) begin
                r.flags.found = 1'b1;
            end else if (held_count >= SLOTS) begin
                r.flags.full = 1'b1;
                if (lo > SLOTS - 1)
                    lo = SLOTS - 1;
            end else begin
                for (i = held_count; i > lo; i--)
                    held_keys[i] = held_keys[i-1];
                held_keys[lo] = k;
                held_count++;
                r.flags.inserted = 1'b1;
            end
            r.position    = POS_W'(lo);
            r.count_after = CNT_W'(held_count);
            owed_results.push_back(r);
        endfunction

        task check_result(input logic found, input logic inserted, input logic full,
                          input logic [POS_W-1:0] position,
                          input logic [CNT_W-1:0] count_after);
            lookup_result_t e;
            if (owed_results.size() == 0) begin
                report("result arrived with no item outstanding");
                return;
            end
            e = owed_results.pop_front();
            if (found !== e.flags.found)
                report($sformatf("found %b, wanted %b", found, e.flags.found));
            if (inserted !== e.flags.inserted)
                report($sformatf("inserted %b, wanted %b", inserted, e.flags.inserted));
            if (full !== e.flags.full)
                report($sformatf("full_res %b, wanted %b", full, e.flags.full));
            if (position !== e.position)
                report($sformatf("position %0d, wanted %0d", position, e.position));
            if (count_after !== e.count_after)
                report($sformatf("count_after %0d, wanted %0d",
                                 count_after, e.count_after));
        endtask
    endclass

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    key_t               s_key   = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_found;
    logic               m_inserted;
    logic               m_full_res;
    logic [POS_W-1:0]   m_position;
    logic [CNT_W-1:0]   m_count_after;

    sorted_table_tracker tracker = new();

    // idling knobs, percent of cycles
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cycle_count    = 0;

    sorted_key_find_or_insert_unit #(
        .CAPACITY (SLOTS),
        .KEY_BITS (KEY_W)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_key         (s_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_inserted    (m_inserted),
        .m_full_res    (m_full_res),
        .m_position    (m_position),
        .m_count_after (m_count_after)
    );

    always #5 aclk = ~aclk;

    // run guard: a hung handshake ends the run as a failure
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver side: random back-pressure, changed on the falling edge
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // both channels sampled at the rising edge; an accepted item updates the
    // shadow table, an accepted result is checked against the oldest one owed
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                tracker.note_request(s_key);
            if (m_valid && m_ready)
                tracker.check_result(m_found, m_inserted, m_full_res,
                                     m_position, m_count_after);
        end
    end

    // offer one key, with a random gap first; returns just after the
    // rising edge that took it, so the next call starts on a falling edge
    task automatic push_key(input key_t k);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_key   <= k;
        do
            @(posedge aclk);
        while (!(s_valid && s_ready));
    endtask

    // sender pause: drop valid and hold off until every result has come
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge aclk);
    endtask

    // key mix: mostly hits on held keys, the rest absent keys of three sorts
    function automatic key_t pick_key(input int unsigned absent_pct);
        key_t        base;
        int unsigned roll;
        base = tracker.held_keys[$urandom_range(tracker.held_count - 1)];
        if ($urandom_range(99) >= absent_pct)
            return base;
        roll = $urandom_range(9);
        if (roll < 4)
            return $urandom_range(1) ? base + 1'b1 : base - 1'b1;
        else if (roll == 4)
            return $urandom_range(1) ? key_t'(0) : key_t'(31'h7FFF_FFFE);
        else
            return key_t'({$urandom(), $urandom()});
    endfunction

    int unsigned phase;
    int unsigned absent_pct;

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: first insert into an empty table, hits, front, end and
        // middle inserts, alternating bit patterns, near-top key
        push_key(31'h4000_0000);
        push_key(31'h4000_0000);
        push_key(31'h0000_0000);
        push_key(31'h6000_0000);
        push_key(31'h5000_0000);
        push_key(31'h0000_0000);
        push_key(31'h6000_0000);
        push_key(31'h2AAA_AAAA);
        push_key(31'h5555_5555);
        push_key(31'h0000_0001);
        push_key(31'h7FFF_FFFE);
        push_key(31'h2AAA_AAAA);
        drain_results();

        // random phases; absent keys stay rare early on so the table fills
        // slowly and its inserts see every idling pattern
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;  recv_stall_pct = 0;  absent_pct = 4;
                end
                1: begin
                    send_idle_pct = 88; recv_stall_pct = 0;  absent_pct = 4;
                end
                2: begin
                    send_idle_pct = 0;  recv_stall_pct = 88; absent_pct = 4;
                end
                default: begin
                    send_idle_pct = 16; recv_stall_pct = 16; absent_pct = 40;
                end
            endcase
            repeat (PHASE_LEN)
                push_key(pick_key(absent_pct));
            drain_results();
        end

        // top up the table if it is not full yet
        while (!tracker.is_full()) begin
            push_key(key_t'({$urandom(), $urandom()}));
            drain_results();
        end

        // full table: key above every entry saturates the slot; held extremes
        // and the smallest held keys still hit
        push_key(31'h7FFF_FFFF);
        push_key(31'h7FFF_FFFF);
        push_key(31'h7FFF_FFFE);
        push_key(31'h0000_0000);
        push_key(tracker.held_keys[0] == 0 ? key_t'(1) : key_t'(0));
        drain_results();

        // allow for a late or stray result
        repeat (TAIL_WAIT) @(posedge aclk);
        while (tracker.pending() != 0) begin
            void'(tracker.owed_results.pop_front());
            tracker.report("expected result never arrived");
        end

        if (tracker.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
